// ----- rtl/rvm_pkg.sv -----
package rvm_pkg;

    localparam int MEM_WORDS_DEF = 32;
    localparam int NUM_REGS_DEF = 8;
    localparam int DATA_W = 32;
    localparam int STEP_W = 16;
    localparam logic [STEP_W-1:0] STEP_LIMIT_RESET = 16'd100;
    localparam logic [STEP_W-1:0] STEP_MAX = 16'hFFFF;

    typedef enum logic [7:0] {
        OP_END   = 8'd0,
        OP_MOV   = 8'd1,
        OP_PRINT = 8'd2,
        OP_MOVQ  = 8'd3,
        OP_ADD   = 8'd4,
        OP_SUB   = 8'd5,
        OP_MUL   = 8'd6,
        OP_EQ    = 8'd7,
        OP_NEQ   = 8'd8,
        OP_JMPIF = 8'd13,
        OP_JMP   = 8'd14,
        OP_LOAD  = 8'd15,
        OP_STORE = 8'd16
    } op_t;

    typedef enum logic [2:0] {
        CAUSE_RUN    = 3'd0,
        CAUSE_END    = 3'd1,
        CAUSE_UNIMPL = 3'd2,
        CAUSE_LIMIT  = 3'd3,
        CAUSE_ADDR   = 3'd4
    } cause_t;

    localparam logic REG_LIMIT = 1'b0;

    typedef struct packed {
        logic              reg_we;
        logic [DATA_W-1:0] reg_wdata;
        logic              mem_we;
        cause_t            halt_next;
        logic [STEP_W-1:0] step_next;
        logic              print_valid;
        logic [DATA_W-1:0] print_value;
        logic              jump_taken;
        logic [DATA_W-1:0] jump_target;
        logic              halted;
    } exec_res_t;

endpackage

// ----- rtl/rvm_regfile.sv -----
module rvm_regfile #(
    parameter int NUM_REGS = rvm_pkg::NUM_REGS_DEF,
    parameter int RW = $clog2(NUM_REGS)
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [RW-1:0]             waddr,
    input  logic [rvm_pkg::DATA_W-1:0] wdata,
    input  logic                      re,
    input  logic [RW-1:0]             raddr0,
    input  logic [RW-1:0]             raddr1,
    output logic [rvm_pkg::DATA_W-1:0] rdata0,
    output logic [rvm_pkg::DATA_W-1:0] rdata1
);

    logic [rvm_pkg::DATA_W-1:0] mem [NUM_REGS];
    logic [rvm_pkg::DATA_W-1:0] rdata0_reg;
    logic [rvm_pkg::DATA_W-1:0] rdata1_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata0_reg <= mem[raddr0];
            rdata1_reg <= mem[raddr1];
        end
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

// ----- rtl/rvm_dmem.sv -----
module rvm_dmem #(
    parameter int MEM_WORDS = rvm_pkg::MEM_WORDS_DEF,
    parameter int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [rvm_pkg::DATA_W-1:0] wdata,
    input  logic                       re,
    input  logic [AW-1:0]              raddr,
    output logic [rvm_pkg::DATA_W-1:0] rdata
);

    logic [rvm_pkg::DATA_W-1:0] mem [MEM_WORDS];
    logic [rvm_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/rvm_alu.sv -----
module rvm_alu (
    input  logic [7:0]                  cmd,
    input  logic [rvm_pkg::DATA_W-1:0]  imm,
    input  logic [rvm_pkg::DATA_W-1:0]  opa,
    input  logic [rvm_pkg::DATA_W-1:0]  opb,
    input  logic [rvm_pkg::DATA_W-1:0]  mem_data,
    input  logic                        addr_ok,
    input  rvm_pkg::cause_t             halt_state,
    input  logic [rvm_pkg::STEP_W-1:0]  step_count,
    input  logic [rvm_pkg::STEP_W-1:0]  step_limit,
    output rvm_pkg::exec_res_t          res
);

    logic executed;

    always_comb
    begin
        executed = 1'b0;
        res = '0;
        res.halt_next = halt_state;
        res.step_next = step_count;
        if (halt_state == rvm_pkg::CAUSE_RUN)
        begin
            executed = 1'b1;
            unique case (rvm_pkg::op_t'(cmd))
                rvm_pkg::OP_END:
                begin
                    res.halt_next = rvm_pkg::CAUSE_END;
                    executed = 1'b0;
                end
                rvm_pkg::OP_MOV:
                begin
                    res.reg_we = 1'b1;
                    res.reg_wdata = opa;
                end
                rvm_pkg::OP_PRINT:
                begin
                    res.print_valid = 1'b1;
                    res.print_value = opa;
                end
                rvm_pkg::OP_MOVQ:
                begin
                    res.reg_we = 1'b1;
                    res.reg_wdata = imm;
                end
                rvm_pkg::OP_ADD:
                begin
                    res.reg_we = 1'b1;
                    res.reg_wdata = opa + opb;
                end
                rvm_pkg::OP_SUB:
                begin
                    res.reg_we = 1'b1;
                    res.reg_wdata = opa - opb;
                end
                rvm_pkg::OP_MUL:
                begin
                    res.reg_we = 1'b1;
                    res.reg_wdata = opa * opb;
                end
                rvm_pkg::OP_EQ:
                begin
                    res.reg_we = 1'b1;
                    res.reg_wdata = {{(rvm_pkg::DATA_W-1){1'b0}}, opa == opb};
                end
                rvm_pkg::OP_NEQ:
                begin
                    res.reg_we = 1'b1;
                    res.reg_wdata = {{(rvm_pkg::DATA_W-1){1'b0}}, opa != opb};
                end
                rvm_pkg::OP_JMPIF:
                begin
                    if (opa != '0)
                    begin
                        res.jump_taken = 1'b1;
                        res.jump_target = imm;
                    end
                end
                rvm_pkg::OP_JMP:
                begin
                    res.jump_taken = 1'b1;
                    res.jump_target = imm;
                end
                rvm_pkg::OP_LOAD:
                begin
                    if (addr_ok)
                    begin
                        res.reg_we = 1'b1;
                        res.reg_wdata = mem_data;
                    end
                    else
                    begin
                        res.halt_next = rvm_pkg::CAUSE_ADDR;
                        executed = 1'b0;
                    end
                end
                rvm_pkg::OP_STORE:
                begin
                    if (addr_ok)
                    begin
                        res.mem_we = 1'b1;
                    end
                    else
                    begin
                        res.halt_next = rvm_pkg::CAUSE_ADDR;
                        executed = 1'b0;
                    end
                end
                default:
                begin
                    res.halt_next = rvm_pkg::CAUSE_UNIMPL;
                    executed = 1'b0;
                end
            endcase
            if (executed)
            begin
                if (step_count != rvm_pkg::STEP_MAX)
                begin
                    res.step_next = step_count + 1'b1;
                end
                if (res.step_next >= step_limit)
                begin
                    res.halt_next = rvm_pkg::CAUSE_LIMIT;
                end
            end
        end
        res.halted = (res.halt_next != rvm_pkg::CAUSE_RUN);
    end

endmodule

// ----- rtl/register_vm_execute_unit.sv -----
// Pipeline: an accepted item waits in the execute registers; its result is registered.
// Throughput: one item per cycle with res_stall low; register and data memory reads
// forward the previous item's write, so dependent items follow back to back.
// Reset: a clearing pass writes zero to max(MEM_WORDS, NUM_REGS) entries, one a cycle,
// during which cmd_stall is high; configuration writes are taken throughout.
module register_vm_execute_unit #(
    parameter int MEM_WORDS = rvm_pkg::MEM_WORDS_DEF,
    parameter int NUM_REGS = rvm_pkg::NUM_REGS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_stall,
    input  logic [7:0]                  cmd,
    input  logic [2:0]                  dst_reg,
    input  logic [2:0]                  src_a,
    input  logic [2:0]                  src_b,
    input  logic signed [31:0]          imm,
    output logic                        res_valid,
    input  logic                        res_stall,
    output logic                        print_valid,
    output logic signed [31:0]          print_value,
    output logic                        jump_taken,
    output logic signed [31:0]          jump_target,
    output logic                        halted,
    output logic [2:0]                  halt_cause,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int DW = rvm_pkg::DATA_W;
    localparam int SW = rvm_pkg::STEP_W;
    localparam int RW = $clog2(NUM_REGS);
    localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int CLR_WORDS = (MEM_WORDS > NUM_REGS) ? MEM_WORDS : NUM_REGS;
    localparam int CW = $clog2(CLR_WORDS);

    logic          accept;
    logic          ex_fire;
    logic [RW-1:0] rd_addr0;

    logic          clearing_reg;
    logic [CW-1:0] clr_idx_reg;

    logic          ex_valid_reg;
    logic [7:0]    ex_cmd_reg;
    logic [RW-1:0] ex_dst_reg;
    logic [RW-1:0] ex_addr0_reg;
    logic [RW-1:0] ex_srcb_reg;
    logic [DW-1:0] ex_imm_reg;

    logic          lwr_valid_reg;
    logic [RW-1:0] lwr_addr_reg;
    logic [DW-1:0] lwr_data_reg;
    logic          lwm_valid_reg;
    logic [AW-1:0] lwm_addr_reg;
    logic [DW-1:0] lwm_data_reg;

    rvm_pkg::cause_t halt_reg;
    logic [SW-1:0]   step_reg;
    logic [SW-1:0]   limit_reg;

    logic          res_valid_reg;
    logic          res_print_valid_reg;
    logic [DW-1:0] res_print_value_reg;
    logic          res_jump_taken_reg;
    logic [DW-1:0] res_jump_target_reg;
    logic          res_halted_reg;
    logic [2:0]    res_cause_reg;

    logic [DW-1:0] rf_rd0;
    logic [DW-1:0] rf_rd1;
    logic [DW-1:0] dm_rd;
    logic [DW-1:0] opa;
    logic [DW-1:0] opb;
    logic [DW-1:0] mem_data;
    logic          addr_ok;
    logic [AW-1:0] ex_maddr;

    logic          rf_we;
    logic [RW-1:0] rf_waddr;
    logic [DW-1:0] rf_wdata;
    logic          dm_we;
    logic [AW-1:0] dm_waddr;
    logic [DW-1:0] dm_wdata;

    logic          cfg_write;

    rvm_pkg::exec_res_t ex_res;

    assign ex_fire = ex_valid_reg && (!res_valid_reg || !res_stall);
    assign cmd_stall = clearing_reg || (ex_valid_reg && !ex_fire);
    assign accept = cmd_valid && !cmd_stall;

    always_comb
    begin
        if ((rvm_pkg::op_t'(cmd) == rvm_pkg::OP_PRINT)
            || (rvm_pkg::op_t'(cmd) == rvm_pkg::OP_JMPIF))
        begin
            rd_addr0 = dst_reg[RW-1:0];
        end
        else
        begin
            rd_addr0 = src_a[RW-1:0];
        end
    end

    // Clearing pass after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_idx_reg <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_idx_reg == CW'(CLR_WORDS - 1))
            begin
                clearing_reg <= 1'b0;
            end
            else
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            ex_valid_reg <= 1'b1;
        end
        else if (ex_fire)
        begin
            ex_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ex_cmd_reg <= cmd;
            ex_dst_reg <= dst_reg[RW-1:0];
            ex_addr0_reg <= rd_addr0;
            ex_srcb_reg <= src_b[RW-1:0];
            ex_imm_reg <= imm;
        end
    end

    rvm_regfile #(
        .NUM_REGS (NUM_REGS),
        .RW       (RW)
    ) u_regfile (
        .clk    (clk),
        .we     (rf_we),
        .waddr  (rf_waddr),
        .wdata  (rf_wdata),
        .re     (accept),
        .raddr0 (rd_addr0),
        .raddr1 (src_b[RW-1:0]),
        .rdata0 (rf_rd0),
        .rdata1 (rf_rd1)
    );

    rvm_dmem #(
        .MEM_WORDS (MEM_WORDS),
        .AW        (AW)
    ) u_dmem (
        .clk   (clk),
        .we    (dm_we),
        .waddr (dm_waddr),
        .wdata (dm_wdata),
        .re    (accept),
        .raddr (imm[AW-1:0]),
        .rdata (dm_rd)
    );

    assign ex_maddr = ex_imm_reg[AW-1:0];
    assign addr_ok = ex_imm_reg < 32'(MEM_WORDS);

    always_comb
    begin
        opa = rf_rd0;
        opb = rf_rd1;
        mem_data = dm_rd;
        if (lwr_valid_reg && (lwr_addr_reg == ex_addr0_reg))
        begin
            opa = lwr_data_reg;
        end
        if (lwr_valid_reg && (lwr_addr_reg == ex_srcb_reg))
        begin
            opb = lwr_data_reg;
        end
        if (lwm_valid_reg && (lwm_addr_reg == ex_maddr))
        begin
            mem_data = lwm_data_reg;
        end
    end

    rvm_alu u_alu (
        .cmd        (ex_cmd_reg),
        .imm        (ex_imm_reg),
        .opa        (opa),
        .opb        (opb),
        .mem_data   (mem_data),
        .addr_ok    (addr_ok),
        .halt_state (halt_reg),
        .step_count (step_reg),
        .step_limit (limit_reg),
        .res        (ex_res)
    );

    always_comb
    begin
        if (clearing_reg)
        begin
            rf_we = {1'b0, clr_idx_reg} < (CW + 1)'(NUM_REGS);
            rf_waddr = clr_idx_reg[RW-1:0];
            rf_wdata = '0;
            dm_we = {1'b0, clr_idx_reg} < (CW + 1)'(MEM_WORDS);
            dm_waddr = clr_idx_reg[AW-1:0];
            dm_wdata = '0;
        end
        else
        begin
            rf_we = ex_fire && ex_res.reg_we;
            rf_waddr = ex_dst_reg;
            rf_wdata = ex_res.reg_wdata;
            dm_we = ex_fire && ex_res.mem_we;
            dm_waddr = ex_maddr;
            dm_wdata = opa;
        end
    end

    // The most recent write to each memory, for the item read in the same cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lwr_valid_reg <= 1'b0;
            lwm_valid_reg <= 1'b0;
        end
        else if (ex_fire)
        begin
            lwr_valid_reg <= ex_res.reg_we;
            lwm_valid_reg <= ex_res.mem_we;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ex_fire)
        begin
            lwr_addr_reg <= ex_dst_reg;
            lwr_data_reg <= ex_res.reg_wdata;
            lwm_addr_reg <= ex_maddr;
            lwm_data_reg <= opa;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halt_reg <= rvm_pkg::CAUSE_RUN;
            step_reg <= '0;
        end
        else if (ex_fire)
        begin
            halt_reg <= ex_res.halt_next;
            step_reg <= ex_res.step_next;
        end
    end

    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= rvm_pkg::STEP_LIMIT_RESET;
        end
        else if (cfg_write && (paddr[2] == rvm_pkg::REG_LIMIT))
        begin
            limit_reg <= pwdata[SW-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == rvm_pkg::REG_LIMIT)
        begin
            prdata = {{(32 - SW){1'b0}}, limit_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (ex_fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ex_fire)
        begin
            res_print_valid_reg <= ex_res.print_valid;
            res_print_value_reg <= ex_res.print_value;
            res_jump_taken_reg <= ex_res.jump_taken;
            res_jump_target_reg <= ex_res.jump_target;
            res_halted_reg <= ex_res.halted;
            res_cause_reg <= ex_res.halt_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign print_valid = res_print_valid_reg;
    assign print_value = res_print_value_reg;
    assign jump_taken = res_jump_taken_reg;
    assign jump_target = res_jump_target_reg;
    assign halted = res_halted_reg;
    assign halt_cause = res_cause_reg;

endmodule
